FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the session table.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that an expression is never true on a rising clock edge.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   `ASSERT_CLK(label, clk, rst, !(expr), msg)

`endif

FILE: rtl/stwsc_pkg.sv
// Shared types and constants of the session table with skew check.
// Depends on nothing; every other file of the block but assert_macros.svh imports it.
package stwsc_pkg;

   localparam int ENTRIES  = 32;
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int WORD_W   = 32;
   localparam int SLOT_W   = 5;
   localparam int STATUS_W = 3;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [IDX_W-1:0]  idx_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_NO_NICK = 3'd1,
      ST_NO_HOST = 3'd2,
      ST_SKEW    = 3'd3,
      ST_CHECK   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DIFF,
      S_ABS,
      S_SKEW,
      S_CHECK,
      S_FINISH
   } state_type;

   // One row of the session table.
   typedef struct packed {
      word_type nickname;
      word_type window;
      word_type last_seen;
   } row_type;

   // Write command into the session table.
   typedef struct packed {
      logic    en;
      idx_type addr;
      row_type row;
   } wr_type;

   // Result of the shared subtractor.
   typedef struct packed {
      word_type diff;
      logic     borrow;
      logic     zero;
   } alu_res_type;

   // Latched request fields.
   typedef struct packed {
      logic     mode;
      word_type lookup_nickname;
      logic     host_known;
      word_type fresh_nickname;
      word_type skew_window;
      word_type stamp;
      word_type stamp_check;
      word_type now_seconds;
   } req_type;

   // Finished response handed to the output register.
   typedef struct packed {
      logic              fire;
      status_type        status;
      logic [SLOT_W-1:0] slot;
      word_type          nickname;
   } rsp_type;

endpackage

FILE: rtl/stwsc_alu.sv
// Shared 32-bit subtractor used for the scan compares and the differences of the block.
// Depends on stwsc_pkg.
module stwsc_alu (
   input  stwsc_pkg::word_type    op_a,
   input  stwsc_pkg::word_type    op_b,
   output stwsc_pkg::alu_res_type res
);
   import stwsc_pkg::*;

   logic [WORD_W:0] sub;

   // One subtraction gives the difference, the borrow (a below b) and equality.
   always_comb begin
      sub        = {1'b0, op_a} - {1'b0, op_b};
      res.diff   = sub[WORD_W-1:0];
      res.borrow = sub[WORD_W];
      res.zero   = (sub[WORD_W-1:0] == '0);
   end

endmodule

FILE: rtl/stwsc_store.sv
// Session table memory: one registered read port, one write port, per-entry valid bits.
// Depends on stwsc_pkg.
module stwsc_store (
   input  logic                 clock,
   input  logic                 reset,
   input  stwsc_pkg::idx_type   rd_addr,
   output stwsc_pkg::row_type   rd_row,
   input  stwsc_pkg::wr_type    wr
);
   import stwsc_pkg::*;

   row_type              mem_ff [ENTRIES];
   logic [ENTRIES-1:0]   valid_ff;
   row_type              rd_row_ff;
   logic                 rd_valid_ff;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.row;
      end
      rd_row_ff <= mem_ff[rd_addr];
   end

   // Valid bits: an entry never written reads as all zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_row = rd_valid_ff ? rd_row_ff : '0;

endmodule

FILE: rtl/stwsc_ctrl.sv
// Sequencer of the session table: table scan, skew and check word tests, write back.
// Depends on stwsc_pkg; drives the shared subtractor and the table memory.
module stwsc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  stwsc_pkg::req_type     req_in,
   output logic                   req_ready,
   input  logic                   out_free,
   output stwsc_pkg::idx_type     rd_addr,
   input  stwsc_pkg::row_type     rd_row,
   output stwsc_pkg::word_type    alu_a,
   output stwsc_pkg::word_type    alu_b,
   input  stwsc_pkg::alu_res_type alu_res,
   output stwsc_pkg::wr_type      wr,
   output stwsc_pkg::rsp_type     rsp
);
   import stwsc_pkg::*;

   localparam idx_type LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type          state_ff, state_in;
   req_type            req_ff, req_in_d;
   logic [CNT_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic               cmp_vld_ff, cmp_vld_in;
   idx_type            cmp_idx_ff, cmp_idx_in;
   idx_type            best_ff, best_in;
   word_type           min_ff, min_in;
   idx_type            slot_ff, slot_in;
   word_type           nick_ff, nick_in;
   word_type           window_ff, window_in;
   word_type           ls_ff, ls_in;
   word_type           diff_ff, diff_in;
   logic               neg_ff, neg_in;
   status_type         status_ff, status_in;

   logic               hit_lookup;
   logic               free_slot;
   logic               new_min;
   logic               last_cmp;
   logic               scan_done;
   logic               ok;
   idx_type            chosen;

   // Per-entry decisions of the scan, from the registered read data.
   always_comb begin
      hit_lookup = cmp_vld_ff && !req_ff.mode && (rd_row.nickname != '0) && alu_res.zero;
      free_slot  = cmp_vld_ff && req_ff.mode && (rd_row.nickname == '0);
      new_min    = cmp_vld_ff && req_ff.mode && ((cmp_idx_ff == '0) || alu_res.borrow);
      last_cmp   = cmp_vld_ff && (cmp_idx_ff == LAST_IDX);
      scan_done  = hit_lookup || free_slot || last_cmp;
      chosen     = (free_slot || new_min) ? cmp_idx_ff : best_ff;
      ok         = (status_ff == ST_OK);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               if (req_ff.mode) begin
                  state_in = req_ff.host_known ? S_DIFF : S_FINISH;
               end else begin
                  state_in = hit_lookup ? S_DIFF : S_FINISH;
               end
            end
         end
         S_DIFF:  state_in = S_ABS;
         S_ABS:   state_in = S_SKEW;
         S_SKEW: begin
            state_in = alu_res.borrow ? S_FINISH : S_CHECK;
         end
         S_CHECK: state_in = S_FINISH;
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath control: operand selection, register updates, memory and response.
   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      req_in_d   = req_ff;
      rd_cnt_in  = rd_cnt_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      best_in    = best_ff;
      min_in     = min_ff;
      slot_in    = slot_ff;
      nick_in    = nick_ff;
      window_in  = window_ff;
      ls_in      = ls_ff;
      diff_in    = diff_ff;
      neg_in     = neg_ff;
      status_in  = status_ff;
      rd_addr    = rd_cnt_ff[IDX_W-1:0];
      alu_a      = '0;
      alu_b      = '0;
      wr         = '0;
      rsp        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in_d  = req_in;
               rd_cnt_in = '0;
            end
         end
         S_SCAN: begin
            // Compare either nicknames or the last-seen time against the running minimum.
            if (req_ff.mode) begin
               alu_a = rd_row.last_seen;
               alu_b = min_ff;
            end else begin
               alu_a = rd_row.nickname;
               alu_b = req_ff.lookup_nickname;
            end
            // Issue the next read while the previous entry is compared.
            if (rd_cnt_ff < CNT_W'(ENTRIES)) begin
               rd_cnt_in  = rd_cnt_ff + 1'b1;
               cmp_vld_in = !scan_done;
               cmp_idx_in = rd_cnt_ff[IDX_W-1:0];
            end
            if (new_min) begin
               best_in = cmp_idx_ff;
               min_in  = rd_row.last_seen;
            end
            if (scan_done) begin
               if (!req_ff.mode) begin
                  if (hit_lookup) begin
                     slot_in   = cmp_idx_ff;
                     nick_in   = rd_row.nickname;
                     window_in = rd_row.window;
                     ls_in     = rd_row.last_seen;
                     status_in = ST_OK;
                  end else begin
                     slot_in   = '0;
                     status_in = ST_NO_NICK;
                  end
               end else begin
                  // The chosen entry is cleared before it is reused.
                  slot_in = chosen;
                  ls_in   = '0;
                  if (req_ff.host_known) begin
                     nick_in   = req_ff.fresh_nickname;
                     window_in = req_ff.skew_window;
                     status_in = ST_OK;
                  end else begin
                     nick_in   = '0;
                     window_in = '0;
                     status_in = ST_NO_HOST;
                  end
               end
            end
         end
         S_DIFF: begin
            alu_a   = req_ff.now_seconds;
            alu_b   = req_ff.stamp;
            diff_in = alu_res.diff;
            neg_in  = alu_res.borrow;
         end
         S_ABS: begin
            // Negate the difference when the stamp lies ahead of now.
            alu_a = '0;
            alu_b = diff_ff;
            if (neg_ff) begin
               diff_in = alu_res.diff;
            end
         end
         S_SKEW: begin
            alu_a = window_ff;
            alu_b = diff_ff;
            if (alu_res.borrow) begin
               status_in = ST_SKEW;
            end
         end
         S_CHECK: begin
            // The check word must be the stamp minus one.
            alu_a = req_ff.stamp;
            alu_b = req_ff.stamp_check;
            if (alu_res.diff != word_type'(1)) begin
               status_in = ST_CHECK;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               wr.en               = (status_ff != ST_NO_NICK);
               wr.addr             = slot_ff;
               wr.row.nickname     = ok ? nick_ff : '0;
               wr.row.window       = window_ff;
               wr.row.last_seen    = ok ? req_ff.now_seconds : ls_ff;
               rsp.fire            = 1'b1;
               rsp.status          = status_ff;
               rsp.slot            = SLOT_W'(slot_ff);
               rsp.nickname        = ok ? nick_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cmp_vld_ff <= 1'b0;
         rd_cnt_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         rd_cnt_ff  <= rd_cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff     <= req_in_d;
      cmp_idx_ff <= cmp_idx_in;
      best_ff    <= best_in;
      min_ff     <= min_in;
      slot_ff    <= slot_in;
      nick_ff    <= nick_in;
      window_ff  <= window_in;
      ls_ff      <= ls_in;
      diff_ff    <= diff_in;
      neg_ff     <= neg_in;
      status_ff  <= status_in;
   end

endmodule

FILE: rtl/session_table_with_skew_check.sv
// Session table of ENTRIES entries (32) with a clock-skew and check word test. A request
// either looks up a session by nickname or creates one in the first free entry, evicting
// the least recently seen entry when none is free. The table sits in a memory read one
// entry per clock. A request runs through a scan of the table, up to four steps of the
// shared subtractor for the skew and check word tests, write back and an idle state in
// which the next request is taken. The fastest request is a new session for an unknown
// host that finds the first entry free. Write back waits while the output register still
// holds a response that has not been taken. The response waits in an output register, so
// the next request can be taken while the previous response is still pending. No clearing
// pass follows reset.
// Depends on stwsc_pkg, stwsc_alu, stwsc_store and stwsc_ctrl.
module session_table_with_skew_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  stwsc_pkg::word_type                  req_lookup_nickname,
   input  logic                                 req_host_known,
   input  stwsc_pkg::word_type                  req_fresh_nickname,
   input  stwsc_pkg::word_type                  req_skew_window,
   input  stwsc_pkg::word_type                  req_stamp,
   input  stwsc_pkg::word_type                  req_stamp_check,
   input  stwsc_pkg::word_type                  req_now_seconds,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [stwsc_pkg::STATUS_W-1:0]       rsp_status,
   output logic [stwsc_pkg::SLOT_W-1:0]         rsp_slot,
   output stwsc_pkg::word_type                  rsp_session_nickname
);
   import stwsc_pkg::*;

   req_type      req_bus;
   idx_type      rd_addr;
   row_type      rd_row;
   word_type     alu_a;
   word_type     alu_b;
   alu_res_type  alu_res;
   wr_type       wr;
   rsp_type      rsp;
   logic         out_free;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   word_type             rsp_nick_ff;

   // Gather the request ports.
   always_comb begin
      req_bus.mode            = req_mode;
      req_bus.lookup_nickname = req_lookup_nickname;
      req_bus.host_known      = req_host_known;
      req_bus.fresh_nickname  = req_fresh_nickname;
      req_bus.skew_window     = req_skew_window;
      req_bus.stamp           = req_stamp;
      req_bus.stamp_check     = req_stamp_check;
      req_bus.now_seconds     = req_now_seconds;
   end

   stwsc_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

   stwsc_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_row  (rd_row),
      .wr      (wr)
   );

   stwsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_in    (req_bus),
      .req_ready (req_ready),
      .out_free  (out_free),
      .rd_addr   (rd_addr),
      .rd_row    (rd_row),
      .alu_a     (alu_a),
      .alu_b     (alu_b),
      .alu_res   (alu_res),
      .wr        (wr),
      .rsp       (rsp)
   );

   // The output register can take a response when empty or being emptied.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp.fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp.fire) begin
         rsp_status_ff <= rsp.status;
         rsp_slot_ff   <= rsp.slot;
         rsp_nick_ff   <= rsp.nickname;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_session_nickname = rsp_nick_ff;

endmodule

FILE: rtl/stwsc_checker.sv
// Port-level checker of the session table, bound to the top level.
// Depends on stwsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stwsc_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_mode,
   input  stwsc_pkg::word_type                  req_lookup_nickname,
   input  logic                                 req_host_known,
   input  stwsc_pkg::word_type                  req_fresh_nickname,
   input  stwsc_pkg::word_type                  req_skew_window,
   input  stwsc_pkg::word_type                  req_stamp,
   input  stwsc_pkg::word_type                  req_stamp_check,
   input  stwsc_pkg::word_type                  req_now_seconds,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [stwsc_pkg::STATUS_W-1:0]       rsp_status,
   input  logic [stwsc_pkg::SLOT_W-1:0]         rsp_slot,
   input  stwsc_pkg::word_type                  rsp_session_nickname
);
   import stwsc_pkg::*;

   // A request keeps the block busy for at least the following cycle.
   `ASSERT_CLK(a_busy_after_req, clock, reset, req_valid && req_ready |=> !req_ready, "ready after request")

   // A failed request never hands out a nickname.
   `ASSERT_CLK(a_fail_no_nick, clock, reset, rsp_valid && (rsp_status != ST_OK) |-> (rsp_session_nickname == '0), "nickname on failure")

   // An unknown nickname reports slot zero.
   `ASSERT_CLK(a_unknown_slot, clock, reset, rsp_valid && (rsp_status == ST_NO_NICK) |-> (rsp_slot == '0), "slot on unknown nickname")

   // A stalled response holds its nickname.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_session_nickname), "response dropped")

endmodule

bind session_table_with_skew_check stwsc_checker u_stwsc_checker (.*);

FILE: dv/tb_session_table_with_skew_check.sv
// Self-checking testbench for the session table with skew check: a directed table of
// requests, then random session traffic, with random stalls on both handshakes.
// Depends on stwsc_pkg and the session_table_with_skew_check RTL.
`timescale 1ns / 100ps

module tb_session_table_with_skew_check;
   import stwsc_pkg::*;

   localparam int PLAN_LEN     = 18;
   localparam int RANDOM_ITEMS = 1630;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 60;

   // One response as the block should produce it.
   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      word_type          nickname;
   } reply_type;

   // One row of the directed table; the expectation is used only where typed is set.
   typedef struct {
      logic              mode;
      word_type          lnick;
      logic              host;
      word_type          fnick;
      word_type          win;
      word_type          stamp;
      word_type          chk;
      word_type          now;
      bit                typed;
      status_type        st;
      logic [SLOT_W-1:0] slot;
      word_type          nick;
   } probe_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_mode;
   word_type            req_lookup_nickname;
   logic                req_host_known;
   word_type            req_fresh_nickname;
   word_type            req_skew_window;
   word_type            req_stamp;
   word_type            req_stamp_check;
   word_type            req_now_seconds;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   word_type            rsp_session_nickname;

   // Shadow copy of the session table.
   word_type  tbl_nick   [ENTRIES];
   word_type  tbl_window [ENTRIES];
   word_type  tbl_seen   [ENTRIES];

   reply_type     pending_replies [$];
   probe_row_type plan [PLAN_LEN];
   bit            failed;
   int            tx_calm;
   int            rx_calm;
   word_type      wall_clock;
   int            idle_cycles;

   session_table_with_skew_check u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_lookup_nickname  (req_lookup_nickname),
      .req_host_known       (req_host_known),
      .req_fresh_nickname   (req_fresh_nickname),
      .req_skew_window      (req_skew_window),
      .req_stamp            (req_stamp),
      .req_stamp_check      (req_stamp_check),
      .req_now_seconds      (req_now_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_slot             (rsp_slot),
      .rsp_session_nickname (rsp_session_nickname)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one request to the shadow table and return the response it should give.
   function automatic reply_type serve_session(input req_type rq);
      reply_type r;
      int        s;
      word_type  diff;
      r = '{status: ST_NO_NICK, slot: '0, nickname: '0};
      s = -1;
      if (!rq.mode) begin
         // Lookup: lowest matching index; nickname zero never matches.
         if (rq.lookup_nickname != '0) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (s < 0 && tbl_nick[i] == rq.lookup_nickname) s = i;
            end
         end
         if (s < 0) return r;
      end else begin
         // New session: first free entry, else the oldest one, lowest index on ties.
         for (int i = 0; i < ENTRIES; i++) begin
            if (s < 0 && tbl_nick[i] == '0) s = i;
         end
         if (s < 0) begin
            s = 0;
            for (int i = 1; i < ENTRIES; i++) begin
               if (tbl_seen[i] < tbl_seen[s]) s = i;
            end
         end
         tbl_nick[s]   = '0;
         tbl_window[s] = '0;
         tbl_seen[s]   = '0;
         r.slot = SLOT_W'(s);
         if (!rq.host_known) begin
            r.status = ST_NO_HOST;
            return r;
         end
         tbl_window[s] = rq.skew_window;
         tbl_nick[s]   = rq.fresh_nickname;
      end
      r.slot = SLOT_W'(s);
      diff = (rq.now_seconds > rq.stamp) ? rq.now_seconds - rq.stamp
                                         : rq.stamp - rq.now_seconds;
      // The skew test takes precedence over the check word test.
      if (diff > tbl_window[s]) begin
         tbl_nick[s] = '0;
         r.status = ST_SKEW;
         return r;
      end
      if (rq.stamp_check != rq.stamp - 32'd1) begin
         tbl_nick[s] = '0;
         r.status = ST_CHECK;
         return r;
      end
      tbl_seen[s] = rq.now_seconds;
      r.status    = ST_OK;
      r.nickname  = tbl_nick[s];
      return r;
   endfunction

   // Idle cycles before the next transfer, with occasional stretches of none at all.
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(20, 50);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   // A skew window: zero, small, anything, or the widest.
   function automatic word_type pick_window();
      case ($urandom_range(0, 3))
         0: begin
            return '0;
         end
         1: begin
            return $urandom_range(0, 20);
         end
         2: begin
            return $urandom;
         end
         default: begin
            return '1;
         end
      endcase
   endfunction

   // A stamp around now: inside the window when keep is set, else mostly just outside it.
   function automatic word_type stamp_near(input word_type now, input word_type win,
                                           input bit keep);
      word_type delta;
      if (keep) begin
         if (win < 64) delta = $urandom_range(0, win);
         else if ($urandom_range(0, 3) == 0) delta = win;
         else delta = $urandom_range(0, 64);
      end else begin
         if (win >= 32'hFFFF_FFF0) delta = '0;
         else delta = win + 32'd1 + $urandom_range(0, 5);
      end
      if ($urandom_range(0, 1) == 0 && now >= delta) return now - delta;
      if (32'hFFFF_FFFF - now >= delta) return now + delta;
      if (now >= delta) return now - delta;
      return now;
   endfunction

   // Random request: mostly well-formed session traffic, the rest noise.
   function automatic req_type next_request();
      req_type rq;
      int      live [$];
      int      roll;
      int      pick;
      rq.mode            = 1'($urandom);
      rq.lookup_nickname = $urandom;
      rq.host_known      = 1'($urandom);
      rq.fresh_nickname  = $urandom;
      rq.skew_window     = $urandom;
      rq.stamp           = $urandom;
      rq.stamp_check     = $urandom;
      rq.now_seconds     = $urandom;
      // A slowly moving clock; a step of zero gives equal timestamps for eviction ties.
      if ($urandom_range(0, 199) == 0) wall_clock = $urandom;
      else wall_clock = wall_clock + $urandom_range(0, 3);
      for (int i = 0; i < ENTRIES; i++) begin
         if (tbl_nick[i] != '0) live.push_back(i);
      end
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         rq.mode           = 1'b1;
         rq.host_known     = ($urandom_range(0, 19) != 0);
         rq.skew_window    = pick_window();
         rq.now_seconds    = wall_clock;
         rq.stamp          = stamp_near(wall_clock, rq.skew_window, $urandom_range(0, 9) != 0);
         if ($urandom_range(0, 9) != 0) rq.stamp_check = rq.stamp - 32'd1;
      end else if (roll < 80 && live.size() > 0) begin
         pick               = live[$urandom_range(0, live.size() - 1)];
         rq.mode            = 1'b0;
         rq.lookup_nickname = tbl_nick[pick];
         rq.now_seconds     = wall_clock;
         rq.stamp           = stamp_near(wall_clock, tbl_window[pick],
                                         $urandom_range(0, 9) != 0);
         if ($urandom_range(0, 9) != 0) rq.stamp_check = rq.stamp - 32'd1;
      end else if (roll < 88) begin
         rq.mode = 1'b0;
         if ($urandom_range(0, 3) == 0) rq.lookup_nickname = '0;
      end
      return rq;
   endfunction

   // Offer one request, wait for it to be taken, and record what it should return.
   task automatic send_request(input req_type rq, input bit typed, input reply_type given);
      int        gap;
      reply_type want;
      gap = draw_gap(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_mode            <= rq.mode;
      req_lookup_nickname <= rq.lookup_nickname;
      req_host_known      <= rq.host_known;
      req_fresh_nickname  <= rq.fresh_nickname;
      req_skew_window     <= rq.skew_window;
      req_stamp           <= rq.stamp;
      req_stamp_check     <= rq.stamp_check;
      req_now_seconds     <= rq.now_seconds;
      do @(posedge clock); while (req_ready !== 1'b1);
      want = serve_session(rq);
      pending_replies.push_back(typed ? given : want);
   endtask

   // Response side: random stalls, and every response compared with the oldest expectation.
   initial begin : reply_checker
      int        stall;
      reply_type exp;
      forever begin
         stall = draw_gap(rx_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (reset !== 1'b0 || rsp_valid !== 1'b1);
         if (pending_replies.size() == 0) begin
            $error("response with none outstanding: status %0d slot %0d nickname %h",
                   rsp_status, rsp_slot, rsp_session_nickname);
            failed = 1'b1;
         end else begin
            exp = pending_replies.pop_front();
            if (rsp_status !== exp.status) begin
               $error("status: expected %0d, got %0d", exp.status, rsp_status);
               failed = 1'b1;
            end
            if (rsp_slot !== exp.slot) begin
               $error("slot: expected %0d, got %0d", exp.slot, rsp_slot);
               failed = 1'b1;
            end
            if (rsp_session_nickname !== exp.nickname) begin
               $error("session_nickname: expected %h, got %h", exp.nickname,
                      rsp_session_nickname);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog: too long without any request or response being taken ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main sequence: reset, directed table, random traffic, drain.
   initial begin : stimulus
      req_type rq;
      tx_calm     = 0;
      wall_clock  = $urandom;
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_nick[i]   = '0;
         tbl_window[i] = '0;
         tbl_seen[i]   = '0;
      end
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_mode            <= 1'b0;
      req_lookup_nickname <= '0;
      req_host_known      <= 1'b0;
      req_fresh_nickname  <= '0;
      req_skew_window     <= '0;
      req_stamp           <= '0;
      req_stamp_check     <= '0;
      req_now_seconds     <= '0;

      // Each row: mode, lookup nickname, host known, fresh nickname, window, stamp,
      // check word, now, then the typed expectation if there is one.
      plan = '{
         // Empty table: nickname zero and an all-ones nickname both miss.
         '{1'b0, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
           1'b1, ST_NO_NICK, 5'd0, 32'h0},
         '{1'b0, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h0, 32'h1, 32'h0, 32'h1,
           1'b1, ST_NO_NICK, 5'd0, 32'h0},
         // Unknown host leaves the first entry free.
         '{1'b1, 32'h0, 1'b0, 32'h1234_5678, 32'h9, 32'h5, 32'h4, 32'h5,
           1'b1, ST_NO_HOST, 5'd0, 32'h0},
         // All-ones nickname and timestamps with a zero window.
         '{1'b1, 32'h0, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
           32'hFFFF_FFFF, 1'b1, ST_OK, 5'd0, 32'hFFFF_FFFF},
         '{1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h5, 32'h4, 32'h5,
           1'b1, ST_OK, 5'd0, 32'hFFFF_FFFF},
         // One second off with a zero window frees the entry.
         '{1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h5, 32'h4, 32'h6,
           1'b1, ST_SKEW, 5'd0, 32'h0},
         // Widest window against the largest possible difference.
         '{1'b1, 32'h0, 1'b1, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
           1'b1, ST_OK, 5'd0, 32'h1},
         // Duplicate nickname, difference exactly at the window.
         '{1'b1, 32'h0, 1'b1, 32'h1, 32'h5, 32'd100, 32'd99, 32'd105,
           1'b1, ST_OK, 5'd1, 32'h1},
         // A lookup of the duplicate finds the lower index.
         '{1'b0, 32'h1, 1'b0, 32'h0, 32'h0, 32'd10, 32'd9, 32'd10,
           1'b1, ST_OK, 5'd0, 32'h1},
         // Bad check word.
         '{1'b1, 32'h0, 1'b1, 32'hA5A5_A5A5, 32'd10, 32'd50, 32'd48, 32'd55,
           1'b1, ST_CHECK, 5'd2, 32'h0},
         // Skew and bad check word together: skew is reported.
         '{1'b1, 32'h0, 1'b1, 32'h5A5A_5A5A, 32'h0, 32'd20, 32'h0, 32'd10,
           1'b1, ST_SKEW, 5'd2, 32'h0},
         // Fresh nickname zero succeeds but leaves the entry free; now behind the stamp.
         '{1'b1, 32'h0, 1'b1, 32'h0, 32'd3, 32'd7, 32'd6, 32'd4,
           1'b1, ST_OK, 5'd2, 32'h0},
         '{1'b0, 32'h0, 1'b1, 32'h0, 32'h0, 32'd7, 32'd6, 32'd7,
           1'b1, ST_NO_NICK, 5'd0, 32'h0},
         '{1'b1, 32'h0, 1'b1, 32'd7, 32'd2, 32'd1000, 32'd999, 32'd1000,
           1'b1, ST_OK, 5'd2, 32'd7},
         // Lookup with the stamp ahead of now by more than the window.
         '{1'b0, 32'd7, 1'b0, 32'h0, 32'h0, 32'd1003, 32'd1002, 32'd1000,
           1'b1, ST_SKEW, 5'd2, 32'h0},
         '{1'b0, 32'd7, 1'b0, 32'h0, 32'h0, 32'd1000, 32'd999, 32'd1000,
           1'b1, ST_NO_NICK, 5'd0, 32'h0},
         '{1'b0, 32'h1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
           32'hFFFF_FFFF, 1'b0, ST_OK, 5'd0, 32'h0},
         '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0F0F_0F0F, 32'h3, 32'h3, 32'h2, 32'h3,
           1'b0, ST_OK, 5'd0, 32'h0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < PLAN_LEN; k++) begin
         rq.mode            = plan[k].mode;
         rq.lookup_nickname = plan[k].lnick;
         rq.host_known      = plan[k].host;
         rq.fresh_nickname  = plan[k].fnick;
         rq.skew_window     = plan[k].win;
         rq.stamp           = plan[k].stamp;
         rq.stamp_check     = plan[k].chk;
         rq.now_seconds     = plan[k].now;
         send_request(rq, plan[k].typed, '{plan[k].st, plan[k].slot, plan[k].nick});
      end

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         rq = next_request();
         send_request(rq, 1'b0, '0);
      end
      req_valid <= 1'b0;

      // Let every outstanding response arrive, then a little longer for strays.
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (!failed && pending_replies.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
